FILE: src/lfr_pkg.sv
// lfr_pkg: shared types, constants and codes of the lfu frame table
// used by lfr_scan and lfu_frame_replacement
package lfr_pkg;

  localparam int MAX_FRAMES = 32;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int ID_W       = 8;
  localparam int CNT_W      = 16;
  localparam int STAMP_W    = 16;
  localparam int CFG_W      = 6;
  localparam int ACT_W      = 2;
  localparam int PADDR_W    = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
  localparam logic [CFG_W-1:0]   FRAMES_RST  = CFG_W'(MAX_FRAMES);
  localparam logic [CFG_W-1:0]   FRAMES_MAX  = CFG_W'(MAX_FRAMES);
  localparam logic [IDX_W-1:0]   LAST_IDX_MAX = IDX_W'(MAX_FRAMES - 1);

  // register index of the configuration port
  localparam logic [PADDR_W-3:0] REG_FRAMES_IN_USE = '0;

  // result action codes
  localparam logic [ACT_W-1:0] ACT_HIT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EVICT = 2'd2;

  // one frame of the table as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } frame_t;

  // control from the sequencer to the scan tracker
  typedef struct packed {
    logic             clear;
    logic             eval;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // findings of one scan
  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    frame_t           match_entry;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
    logic [IDX_W-1:0] victim_idx;
    frame_t           victim_entry;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } seq_state_t;

endpackage

FILE: src/lfr_ram.sv
// lfr_ram: generic single-port synchronous ram with registered read
// no dependencies
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/lfr_scan.sv
// lfr_scan: tracks first match, first empty frame and lfu victim over a scan
// depends on lfr_pkg
module lfr_scan import lfr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  scan_ctl_t       ctl,
  input  logic [ID_W-1:0] cand,
  input  frame_t          entry,
  output scan_res_t       res
);

  logic better;

  // lower count wins, older stamp on a tie, earlier frame otherwise
  assign better = (entry.count < res.victim_entry.count) ||
                  ((entry.count == res.victim_entry.count) &&
                   (entry.stamp < res.victim_entry.stamp));

  // found flags, captured frames and indexes
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res.match_found <= 1'b0;
      res.empty_found <= 1'b0;
    end else if (ctl.eval) begin
      if (!res.match_found && (entry.id == cand)) begin
        res.match_found <= 1'b1;
      end
      if (!res.empty_found && (entry.id == '0)) begin
        res.empty_found <= 1'b1;
      end
    end
    if (ctl.eval) begin
      if (!res.match_found && (entry.id == cand)) begin
        res.match_idx   <= ctl.idx;
        res.match_entry <= entry;
      end
      if (!res.empty_found && (entry.id == '0)) begin
        res.empty_idx <= ctl.idx;
      end
      if ((ctl.idx == '0) || better) begin
        res.victim_idx   <= ctl.idx;
        res.victim_entry <= entry;
      end
    end
  end

endmodule

FILE: src/lfu_frame_replacement.sv
// lfu_frame_replacement: lfu frame table, one frame read per cycle
// the scan reads frames 0 to n-1 in turn, n = active frames, through the
// single ram read port; new words stall until the result word is loaded
// reset clears per-frame valid bits at once (no clearing pass), item index
// to zero and frames_in_use to 32; a zero id is not scanned or written
module lfu_frame_replacement import lfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    candidate_id,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ACT_W-1:0]   action,
  output logic [IDX_W-1:0]   frame_index,
  output logic [ID_W-1:0]    evicted_id,
  output logic [CNT_W-1:0]   hit_count,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  seq_state_t              state, state_next;
  logic [CFG_W-1:0]        frames_in_use;
  logic [STAMP_W-1:0]      item_index;
  logic [ID_W-1:0]         cand;
  logic [STAMP_W-1:0]      stamp;
  logic                    cand_zero;
  logic [IDX_W-1:0]        last_idx, last_idx_cfg;
  logic [IDX_W-1:0]        scan_idx;
  logic                    rd_pend;
  logic [IDX_W-1:0]        rd_idx;
  logic [MAX_FRAMES-1:0]   frame_valid;
  logic                    in_accept, can_load;
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_addr;
  frame_t                  ram_wdata, ram_rdata, entry;
  scan_ctl_t               scan_ctl;
  scan_res_t               scan_res;
  logic [ACT_W-1:0]        res_action;
  logic [IDX_W-1:0]        res_idx;
  logic [ID_W-1:0]         res_evicted;
  logic [CNT_W-1:0]        res_hits;
  logic                    res_write;
  frame_t                  res_frame;
  logic [CNT_W-1:0]        match_cnt_inc;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RST;
    end else if (psel && penable && pwrite &&
                 (paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE)) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE) begin
      prdata[CFG_W-1:0] = frames_in_use;
    end
  end

  // last frame taking part, zero acts as one, large values clamp
  always_comb begin
    if (frames_in_use == '0) begin
      last_idx_cfg = '0;
    end else if (frames_in_use > FRAMES_MAX) begin
      last_idx_cfg = LAST_IDX_MAX;
    end else begin
      last_idx_cfg = IDX_W'(frames_in_use - CFG_W'(1));
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign can_load  = !out_valid || !out_stall;

  // word capture and item index
  always_ff @(posedge clk) begin
    if (rst) begin
      item_index <= '0;
    end else if (in_accept && (item_index != STAMP_MAX)) begin
      item_index <= item_index + STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cand      <= candidate_id;
      stamp     <= item_index;
      cand_zero <= (candidate_id == '0);
      last_idx  <= last_idx_cfg;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = scan_idx;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (candidate_id == '0) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        if (scan_idx == last_idx) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        ram_addr = res_idx;
        if (can_load) begin
          ram_we     = res_write;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // scan address and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (in_accept) begin
        scan_idx <= '0;
      end else if (ram_re) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx <= scan_idx;
    end
  end

  // frame valid bits, a frame never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
    end else if (ram_we) begin
      frame_valid[res_idx] <= 1'b1;
    end
  end

  assign entry = frame_valid[rd_idx] ? ram_rdata : '0;

  lfr_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign scan_ctl.clear = in_accept;
  assign scan_ctl.eval  = rd_pend;
  assign scan_ctl.idx   = rd_idx;

  lfr_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .cand  (cand),
    .entry (entry),
    .res   (scan_res)
  );

  // decision after the scan
  assign match_cnt_inc = (scan_res.match_entry.count == CNT_MAX) ?
                         CNT_MAX : scan_res.match_entry.count + CNT_W'(1);

  always_comb begin
    res_action      = ACT_HIT;
    res_idx         = '0;
    res_evicted     = '0;
    res_hits        = '0;
    res_write       = 1'b0;
    res_frame.id    = cand;
    res_frame.count = CNT_W'(1);
    res_frame.stamp = stamp;
    if (cand_zero) begin
      res_write = 1'b0;
    end else if (scan_res.match_found) begin
      res_action      = ACT_HIT;
      res_idx         = scan_res.match_idx;
      res_hits        = match_cnt_inc;
      res_write       = 1'b1;
      res_frame.count = match_cnt_inc;
      res_frame.stamp = scan_res.match_entry.stamp;
    end else if (scan_res.empty_found) begin
      res_action = ACT_FILL;
      res_idx    = scan_res.empty_idx;
      res_hits   = CNT_W'(1);
      res_write  = 1'b1;
    end else begin
      res_action  = ACT_EVICT;
      res_idx     = scan_res.victim_idx;
      res_evicted = scan_res.victim_entry.id;
      res_hits    = CNT_W'(1);
      res_write   = 1'b1;
    end
  end

  assign ram_wdata = res_frame;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_WRITE) && can_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WRITE) && can_load) begin
      action      <= res_action;
      frame_index <= res_idx;
      evicted_id  <= res_evicted;
      hit_count   <= res_hits;
    end
  end

endmodule
